// ----- sv/fpl_pkg.sv -----
// Shared types, constants and helpers for the fixed-point ladder filter.
// Used by fpl_alu, fixed_point_ladder_filter and tb; depends on nothing else.
package fpl_pkg;

    localparam int STAGES       = 4;
    localparam int SAMPLE_WIDTH = 32;
    localparam int COEF_WIDTH   = 32;
    localparam int STG_W        = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CFG_IDX_W    = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF    = 2'd0,
        CFG_RESONANCE = 2'd1,
        CFG_FB_SHIFT  = 2'd2,
        CFG_MODE      = 2'd3
    } t_cfg_idx;

    // Filter modes; the unused code behaves as lowpass.
    typedef enum logic [1:0] {
        MODE_LOWPASS  = 2'd0,
        MODE_HIGHPASS = 2'd1,
        MODE_OVERSAMP = 2'd2,
        MODE_SPARE    = 2'd3
    } t_mode;

    // Operations of the shared arithmetic unit.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_HADD,
        OP_MUL,
        OP_SHL
    } t_op;

    // One request to the shared unit.
    typedef struct packed {
        t_op     op;
        t_sample a;
        t_sample b;
        t_coef   c;
    } t_alu_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MID,
        ST_FB_AVG,
        ST_FB_MUL,
        ST_FB_SHL,
        ST_IN_ADD,
        ST_IN_SUB,
        ST_MUL,
        ST_UPD,
        ST_DIFF,
        ST_POST
    } t_state;

    localparam logic signed [63:0] SMAX = 64'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    // Clamp a wide signed value to the sample range.
    function automatic t_sample sat_wide(input logic signed [63:0] v);
        t_sample r;
        if (v > SMAX) begin
            r = t_sample'(SMAX);
        end else if (v < SMIN) begin
            r = t_sample'(SMIN);
        end else begin
            r = t_sample'(v);
        end
        return r;
    endfunction

endpackage

// ----- sv/fpl_alu.sv -----
// Shared saturating arithmetic unit of the ladder filter: add, subtract,
// halved add, Q31 multiply and left shift. Depends on fpl_pkg.
module fpl_alu import fpl_pkg::*; (
    input  t_alu_req i_req,
    output t_sample  o_res
);

    localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;

    logic signed [63:0]       ext_a;
    logic signed [63:0]       ext_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [63:0]       wide;

    assign ext_a = 64'(i_req.a);
    assign ext_b = 64'(i_req.b);
    assign prod  = PROD_W'(i_req.c) * PROD_W'(i_req.b);

    always_comb begin
        unique case (i_req.op)
            OP_ADD:  wide = ext_a + ext_b;
            OP_SUB:  wide = ext_a - ext_b;
            OP_HADD: wide = (ext_a >>> 1) + (ext_b >>> 1);
            // Product shifted right by 31 with floor, i.e. truncation.
            OP_MUL:  wide = 64'(prod >>> 31);
            OP_SHL:  wide = ext_a <<< i_req.b[1:0];
            default: wide = ext_a;
        endcase
    end

    assign o_res = sat_wide(wide);

endmodule

// ----- sv/fixed_point_ladder_filter.sv -----
// Top level of the fixed-point four-pole ladder filter: stream ports,
// configuration registers and the sequencer. Depends on fpl_pkg, fpl_alu.

// The filter takes one signed Q31 sample per input transaction and returns
// one filtered sample per output transaction. Every operation of the ladder
// (saturating add, subtract, halved add, left shift and the truncating Q31
// multiply) runs through a single shared arithmetic unit, one operation per
// clock while the sequencer is not holding. A ladder run forms the feedback
// term (halved add, multiply, shift) and the first stage input (add,
// subtract), then gives each stage a multiply and an update, with a
// difference step ahead of every further stage, and ends in a post step.
// Lowpass and highpass items run the ladder once after the accept step;
// oversampled items take a midpoint step and then run it twice. The input side is ready only while
// the sequencer is idle. A finished result sits in the output register and
// the next item may be accepted while it waits; the sequencer holds in its
// last step only if a second result is ready before the first was taken.
// Configuration writes are always accepted and should be issued only while
// no item is in flight. Feedback shift code three acts as two and mode code
// three acts as lowpass.
module fixed_point_ladder_filter import fpl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [31:0]          i_s_axis_tdata,  // [31:0] sample_in
    // Output stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [31:0]          o_m_axis_tdata,  // [31:0] sample_out
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // Configuration registers.
    logic [30:0] r_cutoff;
    t_coef       r_resonance;
    logic [1:0]  r_fb_shift;
    t_mode       r_mode;

    // Filter state. The stage ring rotates by one place per stage update, so
    // the stage being worked on always sits in slot 0 and the freshly
    // updated previous stage in the last slot; after a full run the ring is
    // back in order.
    t_sample     r_stage [STAGES];
    t_sample     r_prev_last;
    t_sample     r_prev_in;

    // Working registers.
    t_state      r_state;
    t_state      n_state;
    logic [STG_W-1:0] r_stg;
    logic        r_pass;
    t_sample     r_x;
    t_sample     r_lin;
    t_sample     r_t;
    t_sample     r_half;
    t_sample     r_y;
    logic        r_out_valid;

    t_alu_req    alu_req;
    t_sample     alu_res;
    logic        in_fire;
    logic        out_fire;
    logic        cfg_fire;
    logic        out_blocked;
    logic        last_stage;
    logic        run_again;
    logic        post_done;
    logic [1:0]  shl_amt;
    t_sample     in_sample;

    fpl_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 32'(r_y);

    assign in_fire     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire    = r_out_valid && i_m_axis_tready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign out_blocked = r_out_valid && !i_m_axis_tready;
    assign last_stage  = (r_stg == STG_W'(STAGES - 1));
    assign run_again   = (r_mode == MODE_OVERSAMP) && !r_pass;
    assign post_done   = (r_state == ST_POST) && !run_again && !out_blocked;
    assign in_sample   = t_sample'(i_s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign shl_amt     = (r_fb_shift > 2'd2) ? 2'd0 : 2'd2 - r_fb_shift;

    // Sequencer: next state and the request to the shared unit.
    always_comb begin
        n_state   = r_state;
        alu_req.op = OP_ADD;
        alu_req.a  = r_t;
        alu_req.b  = '0;
        alu_req.c  = r_resonance;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (r_mode == MODE_OVERSAMP) ? ST_MID : ST_FB_AVG;
                end
            end
            ST_MID: begin
                alu_req.op = OP_HADD;
                alu_req.a  = r_x;
                alu_req.b  = r_prev_in;
                n_state    = ST_FB_AVG;
            end
            ST_FB_AVG: begin
                alu_req.op = OP_HADD;
                alu_req.a  = r_stage[STAGES-1];
                alu_req.b  = r_prev_last;
                n_state    = ST_FB_MUL;
            end
            ST_FB_MUL: begin
                alu_req.op = OP_MUL;
                alu_req.b  = r_t;
                alu_req.c  = r_resonance;
                n_state    = ST_FB_SHL;
            end
            ST_FB_SHL: begin
                alu_req.op = OP_SHL;
                alu_req.a  = r_t;
                alu_req.b  = t_sample'(shl_amt);
                n_state    = ST_IN_ADD;
            end
            ST_IN_ADD: begin
                alu_req.op = OP_ADD;
                alu_req.a  = r_t;
                alu_req.b  = r_stage[0];
                n_state    = ST_IN_SUB;
            end
            ST_IN_SUB: begin
                alu_req.op = OP_SUB;
                alu_req.a  = r_lin;
                alu_req.b  = r_t;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                alu_req.op = OP_MUL;
                alu_req.b  = r_t;
                alu_req.c  = t_coef'(r_cutoff);
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                alu_req.op = OP_ADD;
                alu_req.a  = r_stage[0];
                alu_req.b  = r_t;
                n_state    = last_stage ? ST_POST : ST_DIFF;
            end
            ST_DIFF: begin
                alu_req.op = OP_SUB;
                alu_req.a  = r_stage[STAGES-1];
                alu_req.b  = r_stage[0];
                n_state    = ST_MUL;
            end
            ST_POST: begin
                alu_req.a = r_stage[STAGES-1];
                if (r_mode == MODE_HIGHPASS) begin
                    alu_req.op = OP_SUB;
                    alu_req.a  = r_x;
                    alu_req.b  = r_stage[STAGES-1];
                end else if (r_mode == MODE_OVERSAMP) begin
                    alu_req.op = OP_HADD;
                    alu_req.a  = r_half;
                    alu_req.b  = r_stage[STAGES-1];
                end
                if (run_again) begin
                    n_state = ST_FB_AVG;
                end else if (!out_blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff    <= 31'd345505792;
            r_resonance <= 32'sd536870911;
            r_fb_shift  <= 2'd0;
            r_mode      <= MODE_LOWPASS;
        end else if (cfg_fire) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CUTOFF:    r_cutoff    <= i_cfg_data[30:0];
                CFG_RESONANCE: r_resonance <= t_coef'(i_cfg_data);
                CFG_FB_SHIFT:  r_fb_shift  <= i_cfg_data[1:0];
                CFG_MODE:      r_mode      <= t_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Output valid: set when a finished item leaves the sequencer, cleared
    // when the output transaction completes. A new result may replace one
    // that is taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (post_done) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Filter state, counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_stage[k] <= '0;
            end
            r_prev_last <= '0;
            r_prev_in   <= '0;
            r_stg       <= '0;
            r_pass      <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_x    <= in_sample;
                        r_lin  <= in_sample;
                        r_pass <= 1'b0;
                    end
                end
                ST_MID: begin
                    r_lin <= alu_res;
                end
                ST_FB_AVG, ST_FB_MUL, ST_FB_SHL, ST_IN_ADD, ST_IN_SUB, ST_MUL,
                ST_DIFF: begin
                    r_t <= alu_res;
                end
                ST_UPD: begin
                    // The first stage update also retires the old last stage.
                    if (r_stg == '0) begin
                        r_prev_last <= r_stage[STAGES-1];
                    end
                    for (int k = 0; k < STAGES - 1; k++) begin
                        r_stage[k] <= r_stage[k+1];
                    end
                    r_stage[STAGES-1] <= alu_res;
                    r_stg <= last_stage ? '0 : r_stg + 1'b1;
                end
                ST_POST: begin
                    if (run_again) begin
                        r_half <= r_stage[STAGES-1];
                        r_lin  <= r_x;
                        r_pass <= 1'b1;
                    end else if (!out_blocked) begin
                        r_y         <= alu_res;
                        r_pass      <= 1'b0;
                        if (r_mode == MODE_OVERSAMP) begin
                            r_prev_in <= r_x;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The stage counter only moves while stages are being updated.
    a_stg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_MID || r_state == ST_POST) |-> r_stg == '0)
        else $error("stage counter not at zero outside the ladder run");

    // An accepted item always starts the sequencer.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state != ST_IDLE)
        else $error("accepted item did not start the sequencer");

    // The second oversampled pass never outlives its item.
    a_pass_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass |-> r_state != ST_IDLE)
        else $error("second-pass flag set while idle");

    // Leaving the final step toward idle always presents a result.
    a_post_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POST && n_state == ST_IDLE) |=> o_m_axis_tvalid)
        else $error("finished item produced no result");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the fixed-point ladder filter: stream traffic, register
// writes and a bit-accurate predictor of the four-stage ladder.
// Depends on fpl_pkg and fixed_point_ladder_filter only.
module tb;
    import fpl_pkg::*;

    // The run is cut off here if the block stops moving.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS = 150;

    localparam longint SAMPLE_HI = 64'sd2147483647;
    localparam longint SAMPLE_LO = -64'sd2147483648;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    // One step of the opening sequence: either a register write or a sample.
    // For samples, 'known' marks rows whose result is typed in by hand.
    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [31:0] value;
        logic        known;
        logic [31:0] result;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    t_cfg_idx    cfg_index = CFG_CUTOFF;
    logic [31:0] cfg_data = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire         cfg_ready;

    fixed_point_ladder_filter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [31:0] sample_in
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [31:0] sample_out
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Filter outputs still owed by the block, oldest first.
    logic [31:0] expected_samples [$];

    int tx_idle_pct = 22;
    int rx_idle_pct = 68;
    int items_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Shadow of the filter: configuration and ladder state, in wide signed
    // integers so that every saturation can be applied exactly.
    longint      coeff_q31 = 345505792;
    longint      gain_q31 = 536870911;
    logic [1:0]  fb_shift_code = 2'd0;
    t_mode       mode_code = MODE_LOWPASS;
    longint      ladder_stage [STAGES] = '{default: 0};
    longint      ladder_prev_last = 0;
    longint      os_prev_input = 0;

    function automatic longint clamp_sample(input longint v);
        if (v > SAMPLE_HI) return SAMPLE_HI;
        if (v < SAMPLE_LO) return SAMPLE_LO;
        return v;
    endfunction

    // Q31 multiply: exact product, floor shift by 31, then clamp. Two full-scale
    // negative operands land one past the top and clamp to the largest sample.
    function automatic longint q31_product(input longint c, input longint x);
        return clamp_sample((c * x) >>> 31);
    endfunction

    // One pass through the ladder, feedback first and then every stage in turn.
    function automatic longint ladder_pass(input longint x);
        longint last;
        longint fb;
        int     sh;
        // Shift code three is treated like two, leaving the feedback unshifted.
        sh = (fb_shift_code > 2'd2) ? 0 : 2 - int'(fb_shift_code);
        last = ladder_stage[STAGES-1];
        fb = clamp_sample((last >>> 1) + (ladder_prev_last >>> 1));
        fb = clamp_sample(q31_product(gain_q31, fb) <<< sh);
        ladder_stage[0] = clamp_sample(ladder_stage[0] + q31_product(coeff_q31,
            clamp_sample(x - clamp_sample(fb + ladder_stage[0]))));
        ladder_prev_last = last;
        for (int i = 1; i < STAGES; i++) begin
            ladder_stage[i] = clamp_sample(ladder_stage[i] + q31_product(coeff_q31,
                clamp_sample(ladder_stage[i-1] - ladder_stage[i])));
        end
        return ladder_stage[STAGES-1];
    endfunction

    // Filtered sample for one input sample under the current mode.
    function automatic logic [31:0] filter_sample(input logic [31:0] din);
        longint x;
        longint y;
        longint mid;
        x = longint'(signed'(din));
        case (mode_code)
            MODE_HIGHPASS: begin
                y = clamp_sample(x - ladder_pass(x));
            end
            MODE_OVERSAMP: begin
                // Midpoint pass first, then the sample itself; halves are summed.
                mid = clamp_sample((x >>> 1) + (os_prev_input >>> 1));
                y = ladder_pass(mid) >>> 1;
                y = clamp_sample(y + (ladder_pass(x) >>> 1));
                os_prev_input = x;
            end
            default: begin
                // Lowpass, and the spare mode code which behaves the same way.
                y = ladder_pass(x);
            end
        endcase
        return y[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %0s: result %0d got %h want %h", what, results_seen, got,
                 want);
        mismatch_count++;
    endtask

    // Register write. The block must be idle, so the input side is parked and
    // every owed result has to come back first; since each sample yields exactly
    // one result, an empty queue means nothing is left in flight.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        if (s_tvalid) s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_CUTOFF:    coeff_q31 = longint'(val[30:0]);
            CFG_RESONANCE: gain_q31 = longint'(signed'(val));
            CFG_FB_SHIFT:  fb_shift_code = val[1:0];
            CFG_MODE:      mode_code = t_mode'(val[1:0]);
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offers one sample after a random idle gap and records what the filter
    // owes for it once the input transaction completes. The valid line is
    // only lowered while idling, so back-to-back samples keep it high.
    task automatic send_sample(input logic [31:0] sample, input logic known,
                               input logic [31:0] typed);
        logic [31:0] predicted;
        if (cfg_valid) cfg_valid <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge i_clk); while (!s_tready);
        // The predictor always runs so its state follows the block, even when
        // the row carries a hand-typed result.
        predicted = filter_sample(sample);
        expected_samples.push_back(known ? typed : predicted);
        items_sent++;
    endtask

    // Output side: check each output transaction against the oldest owed
    // sample, then decide whether to stall on the next cycle.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tready && m_tvalid) begin
                results_seen++;
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected sample_out", m_tdata, 'x);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want) report_mismatch("sample_out", m_tdata, want);
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     expected_samples.size());
            $display("tb failed");
            $finish;
        end
    end

    t_stim_row opening_rows [31];

    initial begin
        longint      walk;
        logic [31:0] cutoff_val;
        logic [31:0] gain_val;

        // Opening sequence. With the cutoff at zero no stage can move, so the
        // lowpass path stays at zero and highpass passes the input through.
        opening_rows = '{
            // Fresh out of reset, silence in gives silence out.
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h0000_0000, 1'b1, 32'h0000_0000},
            // Bit 31 of the cutoff is dropped, so this writes zero.
            '{ROW_WRITE,  CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_MODE,      {30'd0, MODE_HIGHPASS}, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b1, 32'h8000_0000},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h0000_0001, 1'b1, 32'h0000_0001},
            '{ROW_WRITE,  CFG_MODE,      {30'd0, MODE_OVERSAMP}, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b1, 32'h0000_0000},
            // Spare mode code with junk in the upper bits: acts as lowpass.
            '{ROW_WRITE,  CFG_MODE,      32'hFFFF_FFFF, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'hFFFF_FFFB, 1'b1, 32'h0000_0000},
            // Full-scale cutoff, most negative gain, shift code three. A run of
            // negative full-scale input drives the feedback product toward
            // minus one times minus one.
            '{ROW_WRITE,  CFG_CUTOFF,    32'h7FFF_FFFF, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_RESONANCE, 32'h8000_0000, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_FB_SHIFT,  32'h0000_0003, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_MODE,      {30'd0, MODE_LOWPASS}, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            // Largest positive gain with the biggest feedback shift.
            '{ROW_WRITE,  CFG_RESONANCE, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_FB_SHIFT,  32'h0000_0000, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_MODE,      {30'd0, MODE_HIGHPASS}, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h7FFF_FFFF, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h7FFF_FFFF, 1'b0, 32'h0},
            '{ROW_WRITE,  CFG_MODE,      {30'd0, MODE_OVERSAMP}, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h8000_0000, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h7FFF_FFFF, 1'b0, 32'h0},
            '{ROW_SAMPLE, CFG_CUTOFF,    32'h0000_0000, 1'b0, 32'h0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[r]) begin
            if (opening_rows[r].kind == ROW_WRITE) begin
                write_reg(opening_rows[r].idx, opening_rows[r].value);
            end else begin
                send_sample(opening_rows[r].value, opening_rows[r].known,
                            opening_rows[r].result);
            end
        end

        // Random part. Each phase reprograms all four registers; the first
        // phases pin the extremes, later ones draw at random. Mode and shift
        // codes rotate so that every combination of interest comes up.
        walk = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 4) begin
                tx_idle_pct = 22;
                rx_idle_pct = 68;
            end else if (phase < 8) begin
                tx_idle_pct = 68;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case (phase)
                0: cutoff_val = 32'hFFFF_FFFF;
                1: cutoff_val = 32'h0000_0000;
                default: begin
                    case ($urandom_range(2))
                        0: cutoff_val = $urandom;
                        1: cutoff_val = {1'($urandom), 31'($urandom_range(32'h1000_0000))};
                        default: cutoff_val = $urandom_range(32'h0100_0000);
                    endcase
                end
            endcase
            case (phase)
                0: gain_val = 32'h8000_0000;
                1: gain_val = 32'h0000_0000;
                2: gain_val = 32'h7FFF_FFFF;
                default: gain_val = $urandom;
            endcase
            write_reg(CFG_CUTOFF, cutoff_val);
            write_reg(CFG_RESONANCE, gain_val);
            write_reg(CFG_FB_SHIFT, {30'($urandom), 2'(phase % 4)});
            write_reg(CFG_MODE, {30'($urandom), 2'((phase + phase / 4) % 4)});

            // Mostly a slow random walk, the way audio moves, with full-scale
            // values, silence and uncorrelated noise mixed in.
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(9))
                    0: walk = SAMPLE_HI;
                    1: walk = SAMPLE_LO;
                    2: walk = 0;
                    3, 4: walk = longint'(signed'($urandom));
                    default: walk = clamp_sample(walk + longint'($urandom_range(1 << 25))
                                                 - (64'sd1 << 24));
                endcase
                send_sample(walk[31:0], 1'b0, 32'h0);
            end
        end

        // Drain: park the input, collect every owed sample, then give the block
        // time to show any stray output.
        if (s_tvalid) s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d samples and %0d register writes over all four mode codes,",
                 items_sent, reg_writes);
        $display("every feedback shift code and extreme coefficients; %0d results, %0d bad.",
                 results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ----- fixed_point_ladder_filter.f -----
sv/fpl_pkg.sv
sv/fpl_alu.sv
sv/fixed_point_ladder_filter.sv
tb/tb.sv
